// ===== src/sine_tone_sample_generator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Sine tone sample generator: assertion macros
// Shared property shorthands for the checker; clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef SINE_TONE_SAMPLE_GENERATOR_UNIT_DEFINES_SVH
`define SINE_TONE_SAMPLE_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define STSG_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stsg assertion failed");

// next-cycle implication
`define STSG_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stsg assertion failed");

`endif

// ===== src/stsg_pkg.sv =====
// ----------------------------------------------------------------------------
// stsg_pkg
// Types, register indexes and constants of the sine tone sample generator.
// ----------------------------------------------------------------------------
package stsg_pkg;

	localparam int FREQ_W = 15;
	localparam int AMP_W  = 7;
	localparam int RATE_W = 16;
	localparam int CFG_W  = 16;
	localparam int SMP_W  = 8;

	localparam logic [1:0] CFG_TONE_FREQUENCY = 2'd0;
	localparam logic [1:0] CFG_TONE_AMPLITUDE = 2'd1;
	localparam logic [1:0] CFG_SAMPLE_RATE    = 2'd2;

	localparam logic [FREQ_W-1:0] FREQ_RESET = 15'd440;
	localparam logic [AMP_W-1:0]  AMP_RESET  = 7'd127;
	localparam logic [RATE_W-1:0] RATE_RESET = 16'd44100;

	// pi scaled by 2^62
	localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_MLOAD,
		OP_MSTEP,
		OP_DLOAD,
		OP_DSTEP
	} stsg_op_t;

	// divisor (2i)(2i+1) of series term i
	function automatic logic [9:0] stsg_term_div(input logic [3:0] i);
		logic [9:0] a;
		a = {5'd0, i, 1'b0};
		return 10'(a * (a + 10'd1));
	endfunction

endpackage

// ===== src/stsg_serial_unit.sv =====
// ----------------------------------------------------------------------------
// stsg_serial_unit
// Shared bit-serial shift-add multiplier and restoring divider.
// ----------------------------------------------------------------------------
module stsg_serial_unit import stsg_pkg::*; #(
	parameter int W = 32
) (
	input  logic            clk,
	input  stsg_op_t        op,
	input  logic [W-1:0]    a_in,
	input  logic [W-1:0]    b_in,
	input  logic [2*W-1:0]  dvd_in,
	input  logic [15:0]     dv_in,
	output logic [2*W-1:0]  acc,
	output logic [15:0]     rem,
	output logic [W-1:0]    quo
);

	logic [W-1:0]   a_q;
	logic [W-1:0]   b_q;
	logic [2*W-1:0] acc_q;
	logic [2*W-1:0] dvd_q;
	logic [15:0]    dv_q;
	logic [15:0]    rem_q;
	logic [W-1:0]   quo_q;
	logic [16:0]    rs;
	logic           ge;

	assign rs  = {rem_q, dvd_q[2*W-1]};
	assign ge  = rs >= {1'b0, dv_q};
	assign acc = acc_q;
	assign rem = rem_q;
	assign quo = quo_q;

	always_ff @(posedge clk) begin
		case (op)
			OP_MLOAD: begin
				a_q   <= a_in;
				b_q   <= b_in;
				acc_q <= '0;
			end
			OP_MSTEP: begin
				acc_q <= (acc_q << 1) + (b_q[W-1] ? {{W{1'b0}}, a_q} : '0);
				b_q   <= b_q << 1;
			end
			OP_DLOAD: begin
				dvd_q <= dvd_in;
				dv_q  <= dv_in;
				rem_q <= '0;
				quo_q <= '0;
			end
			OP_DSTEP: begin
				rem_q <= ge ? 16'(rs - {1'b0, dv_q}) : rs[15:0];
				quo_q <= {quo_q[W-2:0], ge};
				dvd_q <= dvd_q << 1;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== src/sine_tone_sample_generator_unit.sv =====
// A tick with preemptible low is accepted in idle and produces no sample.
// Throughput: one tick at a time, set by the shared bit-serial multiply/divide unit.
// A finished sample waits in the output register while the next tick is taken.
// Reset: asynchronous, clears position and handshakes, loads register defaults.
// ----------------------------------------------------------------------------
// sine_tone_sample_generator_unit
// Tone oscillator: phase reduction, Taylor sine in fixed point, amplitude scale.
// ----------------------------------------------------------------------------
module sine_tone_sample_generator_unit import stsg_pkg::*; #(
	parameter int SERIES_TERMS  = 10,
	parameter int FRACTION_BITS = 30
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write_en,
	input  logic [1:0]               cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     preemptible,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [SMP_W-1:0]  sample_value,
	output logic [SMP_W-1:0]         speaker_byte
);

	localparam int F  = FRACTION_BITS;
	localparam int W  = F + 2;
	localparam int PW = 2 * W;
	localparam int CW = $clog2(PW);
	localparam int IW = $clog2(SERIES_TERMS);
	localparam logic [63:0] PI_RND = (PI_Q62 + (64'd1 << (61 - F))) >> (62 - F);
	localparam logic [W-1:0] PI_Q = PI_RND[W-1:0];
	localparam logic [W-1:0] ONE  = W'(1) << F;

	typedef enum logic [4:0] {
		ST_IDLE, ST_PMUL, ST_PMODL, ST_PMOD, ST_PDIVL, ST_PDIV, ST_FOLD,
		ST_XMUL, ST_XDIVL, ST_XDIV, ST_TINIT, ST_TM1, ST_TM2L, ST_TM2,
		ST_TDIVL, ST_TDIV, ST_TACC, ST_AMUL, ST_EMIT
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       cnt_q;
	logic [FREQ_W-1:0]   freq_q;
	logic [AMP_W-1:0]    amp_q;
	logic [RATE_W-1:0]   rate_q;
	logic [15:0]         r_q;
	logic [15:0]         pos_q;
	logic [15:0]         p_q;
	logic                neg_q;
	logic [W-1:0]        x_q;
	logic signed [W:0]   sum_q;
	logic [IW-1:0]       idx_q;
	logic                out_valid_q;
	logic [SMP_W-1:0]    sample_q;
	logic [SMP_W-1:0]    speaker_q;

	stsg_op_t            op;
	logic [W-1:0]        a_in;
	logic [W-1:0]        b_in;
	logic [PW-1:0]       dvd_in;
	logic [15:0]         dv_in;
	logic [PW-1:0]       acc_o;
	logic [15:0]         rem_o;
	logic [W-1:0]        quo_o;

	logic [16:0]         u2;
	logic                fold_neg;
	logic [16:0]         u1;
	logic [15:0]         u;
	logic signed [W:0]   sum_new;
	logic [W-1:0]        sum_clamp;
	logic                last_term;
	logic [AMP_W-1:0]    mag;
	logic [SMP_W-1:0]    smp;
	logic                out_free;

	stsg_serial_unit #(.W(W)) u_unit (
		.clk    (clk),
		.op     (op),
		.a_in   (a_in),
		.b_in   (b_in),
		.dvd_in (dvd_in),
		.dv_in  (dv_in),
		.acc    (acc_o),
		.rem    (rem_o),
		.quo    (quo_o)
	);

	assign u2       = {p_q, 1'b0};
	assign fold_neg = u2 >= {1'b0, r_q};
	assign u1       = fold_neg ? 17'(u2 - {1'b0, r_q}) : u2;
	assign u        = ({u1, 1'b0} > {2'b0, r_q}) ? 16'(r_q - u1[15:0]) : u1[15:0];

	assign sum_new   = idx_q[0] ? (sum_q - $signed({1'b0, quo_o}))
	                            : (sum_q + $signed({1'b0, quo_o}));
	assign sum_clamp = sum_new[W] ? '0 : ((sum_new[W-1:0] > ONE) ? ONE : sum_new[W-1:0]);
	assign last_term = idx_q == IW'(SERIES_TERMS - 1);

	assign mag      = (|acc_o[PW-1:F+AMP_W]) ? AMP_W'(127) : acc_o[F+AMP_W-1:F];
	assign smp      = neg_q ? SMP_W'(~{1'b0, mag} + 8'd1) : {1'b0, mag};
	assign out_free = !out_valid_q || !out_stall;

	assign in_stall     = state_q != ST_IDLE;
	assign out_valid    = out_valid_q;
	assign sample_value = sample_q;
	assign speaker_byte = speaker_q;

	always_comb begin
		op     = OP_HOLD;
		a_in   = '0;
		b_in   = '0;
		dvd_in = '0;
		dv_in  = r_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && preemptible) begin
					op = OP_MLOAD;
				end
				a_in = W'(pos_q);
				b_in = W'(freq_q) << (W - FREQ_W);
			end
			ST_PMODL: begin
				op     = OP_DLOAD;
				dvd_in = acc_o << (PW - 31);
			end
			ST_PDIVL: begin
				op     = OP_DLOAD;
				dvd_in = PW'({1'b0, pos_q} + 17'd1) << (PW - 17);
			end
			ST_FOLD: begin
				op   = OP_MLOAD;
				a_in = PI_Q;
				b_in = W'(u) << (W - 16);
			end
			ST_XDIVL: begin
				op     = OP_DLOAD;
				dvd_in = acc_o << (PW - (F + 18));
			end
			ST_TINIT: begin
				op   = OP_MLOAD;
				a_in = quo_o;
				b_in = quo_o;
			end
			ST_TM2L: begin
				op   = OP_MLOAD;
				a_in = acc_o[F+W-1:F];
				b_in = x_q;
			end
			ST_TDIVL: begin
				op     = OP_DLOAD;
				dvd_in = PW'(acc_o[F+W-1:F]) << (PW - W);
				dv_in  = 16'(stsg_term_div(4'(idx_q)));
			end
			ST_TACC: begin
				op = OP_MLOAD;
				if (last_term) begin
					a_in = sum_clamp;
					b_in = W'(amp_q) << (W - AMP_W);
				end else begin
					a_in = quo_o;
					b_in = x_q;
				end
			end
			ST_PMUL, ST_XMUL, ST_TM1, ST_TM2, ST_AMUL: op = OP_MSTEP;
			ST_PMOD, ST_PDIV, ST_XDIV, ST_TDIV:        op = OP_DSTEP;
			default: op = OP_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			freq_q      <= FREQ_RESET;
			amp_q       <= AMP_RESET;
			rate_q      <= RATE_RESET;
			pos_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					CFG_TONE_FREQUENCY: freq_q <= cfg_data[FREQ_W-1:0];
					CFG_TONE_AMPLITUDE: amp_q  <= cfg_data[AMP_W-1:0];
					CFG_SAMPLE_RATE:    rate_q <= cfg_data[RATE_W-1:0];
					default: begin
					end
				endcase
			end
			if (out_valid_q && !out_stall && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					r_q <= (rate_q == '0) ? 16'd1 : rate_q;
					if (in_valid && preemptible) begin
						cnt_q   <= CW'(FREQ_W - 1);
						state_q <= ST_PMUL;
					end
				end
				ST_PMUL: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= ST_PMODL;
				end
				ST_PMODL: begin
					cnt_q   <= CW'(30);
					state_q <= ST_PMOD;
				end
				ST_PMOD: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= ST_PDIVL;
				end
				ST_PDIVL: begin
					p_q     <= rem_o;
					cnt_q   <= CW'(16);
					state_q <= ST_PDIV;
				end
				ST_PDIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					pos_q   <= rem_o;
					neg_q   <= fold_neg;
					cnt_q   <= CW'(15);
					state_q <= ST_XMUL;
				end
				ST_XMUL: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= ST_XDIVL;
				end
				ST_XDIVL: begin
					cnt_q   <= CW'(F + 17);
					state_q <= ST_XDIV;
				end
				ST_XDIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= ST_TINIT;
				end
				ST_TINIT: begin
					x_q     <= quo_o;
					sum_q   <= $signed({1'b0, quo_o});
					idx_q   <= IW'(1);
					cnt_q   <= CW'(W - 1);
					state_q <= ST_TM1;
				end
				ST_TM1: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= ST_TM2L;
				end
				ST_TM2L: begin
					cnt_q   <= CW'(W - 1);
					state_q <= ST_TM2;
				end
				ST_TM2: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= ST_TDIVL;
				end
				ST_TDIVL: begin
					cnt_q   <= CW'(W - 1);
					state_q <= ST_TDIV;
				end
				ST_TDIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= ST_TACC;
				end
				ST_TACC: begin
					sum_q <= sum_new;
					if (last_term) begin
						cnt_q   <= CW'(AMP_W - 1);
						state_q <= ST_AMUL;
					end else begin
						idx_q   <= idx_q + 1'b1;
						cnt_q   <= CW'(W - 1);
						state_q <= ST_TM1;
					end
				end
				ST_AMUL: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						sample_q    <= smp;
						speaker_q   <= smp | 8'h03;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== src/stsg_checker.sv =====
// ----------------------------------------------------------------------------
// stsg_checker
// Port-level checks of the sine tone sample generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "sine_tone_sample_generator_unit_defines.svh"

module stsg_checker import stsg_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    preemptible,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [SMP_W-1:0] sample_value,
	input logic [SMP_W-1:0]        speaker_byte
);

	`STSG_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
	`STSG_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(sample_value))
	`STSG_ASSERT_IMP(a_speaker, out_valid, speaker_byte == (sample_value | 8'h03))
	`STSG_ASSERT_IMP(a_range, out_valid, sample_value != 8'sh80)
	`STSG_ASSERT_NXT(a_busy, in_valid && !in_stall && preemptible, in_stall)

endmodule

bind sine_tone_sample_generator_unit stsg_checker u_stsg_checker (.*);

// ===== test/sine_tone_sample_generator_unit_checker.sv =====
// ----------------------------------------------------------------------------
// sine_tone_sample_generator_unit_checker
// Watches the register port and both channels, predicts every tone sample
// from its own copy of the registers and the sample position, and compares
// each output transaction field by field with the oldest predicted sample.
// ----------------------------------------------------------------------------
module sine_tone_sample_generator_unit_checker import stsg_pkg::*; #(
	parameter int SERIES_TERMS  = 10,
	parameter int FRACTION_BITS = 30
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write_en,
	input  logic [1:0]              cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic                    preemptible,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic signed [SMP_W-1:0] sample_value,
	input  logic [SMP_W-1:0]        speaker_byte,
	output int                      samples_pending,
	output int                      error_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample;
		logic [SMP_W-1:0]        speaker;
	} tone_sample_t;

	logic [FREQ_W-1:0] freq_q;
	logic [AMP_W-1:0]  amp_q;
	logic [RATE_W-1:0] rate_q;
	logic [RATE_W-1:0] position_q;
	tone_sample_t      sample_fifo[$];

	function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] prod;
		prod = 128'(a) * 128'(b);
		return 64'(prod >> FRACTION_BITS);
	endfunction

	function automatic tone_sample_t tone_at(input logic [RATE_W-1:0] pos);
		logic [63:0] r, p, u, pi_fx, x, term, mag, one, k;
		logic signed [63:0] acc;
		logic neg;
		tone_sample_t res;
		r = (rate_q == 0) ? 64'd1 : 64'(rate_q);
		p = (64'(pos) * 64'(freq_q)) % r;
		u = 2 * p;
		neg = 1'b0;
		if (u >= r) begin
			neg = 1'b1;
			u = u - r;
		end
		if (2 * u > r) u = r - u;
		pi_fx = (PI_Q62 + (64'd1 << (61 - FRACTION_BITS))) >> (62 - FRACTION_BITS);
		x = (u * pi_fx) / r;
		term = x;
		acc = signed'(x);
		one = 64'd1 << FRACTION_BITS;
		for (int i = 1; i < SERIES_TERMS; i++) begin
			k = 64'(2 * i) * 64'(2 * i + 1);
			term = fx_mul(fx_mul(term, x), x) / k;
			if (i % 2 == 1) acc = acc - signed'(term);
			else acc = acc + signed'(term);
		end
		if (acc < 0) acc = 0;
		if (acc > signed'(one)) acc = signed'(one);
		mag = fx_mul(64'(amp_q), 64'(acc));
		if (mag > 127) mag = 127;
		res.sample = neg ? SMP_W'(-mag) : SMP_W'(mag);
		res.speaker = res.sample | 8'h03;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tone_sample_t want;
		logic [63:0] r;
		if (!arst_n) begin
			freq_q <= FREQ_RESET;
			amp_q <= AMP_RESET;
			rate_q <= RATE_RESET;
			position_q <= '0;
			sample_fifo.delete();
			error_count <= 0;
			samples_pending <= 0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					CFG_TONE_FREQUENCY: freq_q <= FREQ_W'(cfg_data);
					CFG_TONE_AMPLITUDE: amp_q <= AMP_W'(cfg_data);
					CFG_SAMPLE_RATE:    rate_q <= RATE_W'(cfg_data);
					default: ;
				endcase
			end
			if (in_valid && !in_stall && preemptible) begin
				sample_fifo.push_back(tone_at(position_q));
				r = (rate_q == 0) ? 64'd1 : 64'(rate_q);
				position_q <= RATE_W'((64'(position_q) + 1) % r);
			end
			if (out_valid && !out_stall) begin
				if (sample_fifo.size() == 0) begin
					$display("%0t: unexpected output transaction sample=%0d speaker=%0h",
						$time, sample_value, speaker_byte);
					error_count <= error_count + 1;
				end else begin
					want = sample_fifo.pop_front();
					if (sample_value !== want.sample || speaker_byte !== want.speaker) begin
						$display("%0t: mismatch sample exp %0d got %0d, speaker exp %0h got %0h",
							$time, want.sample, sample_value, want.speaker, speaker_byte);
						error_count <= error_count + 1;
					end
				end
			end
			samples_pending <= sample_fifo.size();
		end
	end

endmodule

// ===== test/sine_tone_sample_generator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// sine_tone_sample_generator_unit_tb
// Drives timer ticks and register settings into the tone generator, with
// random idling on both channels, a long output hold-off and a drained pause;
// a checker beside the block predicts and compares every sample.
// ----------------------------------------------------------------------------
module sine_tone_sample_generator_unit_tb import stsg_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 16;
	localparam int DRAIN_CYCLES = 1200;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_write_en;
	logic [1:0]              cfg_index;
	logic [CFG_W-1:0]        cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic                    preemptible;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [SMP_W-1:0] sample_value;
	logic [SMP_W-1:0]        speaker_byte;
	int                      samples_pending;
	int                      error_count;

	bit idle_enable;
	bit hold_request;

	sine_tone_sample_generator_unit dut (.*);

	sine_tone_sample_generator_unit_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("sine_tone_sample_generator_unit verification failed");
		$finish;
	end

	// output side: random stall bursts, and one long hold on request
	initial begin
		int left;
		out_stall = 1'b0;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (3000) @(negedge clk);
				hold_request = 1'b0;
				out_stall <= 1'b0;
			end else if (left > 0) begin
				left--;
			end else if (idle_enable && $urandom_range(3) == 0) begin
				out_stall <= 1'b1;
				left = $urandom_range(15, 1) - 1;
			end else begin
				out_stall <= 1'b0;
				left = $urandom_range(10);
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	task automatic set_tone(input int freq, input int amp, input int rate);
		write_reg(CFG_TONE_FREQUENCY, CFG_W'(freq));
		write_reg(CFG_TONE_AMPLITUDE, CFG_W'(amp));
		write_reg(CFG_SAMPLE_RATE, CFG_W'(rate));
	endtask

	// one tick transaction; valid stays high into the next tick
	task automatic send_tick(input bit pre);
		if (idle_enable && $urandom_range(5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(15, 1)) @(negedge clk);
		end
		in_valid <= 1'b1;
		preemptible <= pre;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (samples_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic ticks(input int n);
		for (int i = 0; i < n; i++) send_tick(1'($urandom_range(3) != 0));
		drain();
	endtask

	initial begin
		int rate, freq;
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		preemptible = 1'b0;
		idle_enable = 1'b1;
		hold_request = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults, then extremes of each register
		send_tick(1'b1); send_tick(1'b0); send_tick(1'b1); send_tick(1'b1);
		drain();
		set_tone(0, 127, 44100);
		ticks(2);
		set_tone(32767, 127, 65535);
		ticks(3);
		set_tone(22050, 0, 44100);
		ticks(2);
		write_reg(CFG_SAMPLE_RATE, 16'd0);
		ticks(2);
		write_reg(CFG_SAMPLE_RATE, 16'd1);
		ticks(2);
		set_tone(1, 127, 2);
		ticks(3);
		// position left beyond a lowered rate
		set_tone(1, 127, 65535);
		for (int i = 0; i < 6; i++) send_tick(1'b1);
		drain();
		write_reg(CFG_SAMPLE_RATE, 16'd3);
		write_reg(CFG_UNUSED, 16'hFFFF);
		ticks(3);

		for (int ph = 0; ph < 22; ph++) begin
			if (ph >= 19) idle_enable = 1'b0;
			case ($urandom_range(5))
				0: rate = $urandom_range(1);
				1: rate = $urandom_range(16, 2);
				default: rate = $urandom_range(65535, 2);
			endcase
			freq = ($urandom_range(4) == 0) ? $urandom_range(32767)
				: $urandom_range(rate > 3 ? rate / 2 - 1 : 1, 1);
			if ($urandom_range(3) == 0) begin
				write_reg(CFG_TONE_FREQUENCY, CFG_W'($urandom));
				write_reg(CFG_TONE_AMPLITUDE, CFG_W'($urandom));
			end else begin
				write_reg(CFG_TONE_FREQUENCY, CFG_W'(freq));
				write_reg(CFG_TONE_AMPLITUDE, CFG_W'($urandom_range(127)));
			end
			write_reg(CFG_SAMPLE_RATE, CFG_W'(rate));
			if (ph == 3) hold_request = 1'b1;
			ticks(52);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && samples_pending == 0)
			$display("sine_tone_sample_generator_unit verification clean");
		else
			$display("sine_tone_sample_generator_unit verification failed");
		$finish;
	end

endmodule

// ===== sine_tone_sample_generator_unit.f =====
+incdir+src
src/stsg_pkg.sv
src/stsg_serial_unit.sv
src/sine_tone_sample_generator_unit.sv
src/stsg_checker.sv
test/sine_tone_sample_generator_unit_checker.sv
test/sine_tone_sample_generator_unit_tb.sv
